// File: src/rgb_gaussian_blur_3x3_core_macros.svh
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clk_i,
// disabled while rst_ni is low.
`ifndef RGB_GAUSSIAN_BLUR_3X3_CORE_MACROS_SVH
`define RGB_GAUSSIAN_BLUR_3X3_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rgbg_pkg.sv
package rgbg_pkg;

  // Line store geometry.
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned IdxW      = $clog2(MaxWidth);

  // Field widths.
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;
  localparam int unsigned ColSumW = ChanW + 2;
  localparam int unsigned WinSumW = ChanW + 4;
  localparam int unsigned WidthW  = 12;
  localparam int unsigned HeightW = 13;
  localparam int unsigned ColW    = 11;
  localparam int unsigned RowW    = 12;
  localparam int unsigned AddrW   = 3;

  // Result queue depth, enough to cover the two stages ahead of it.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Register indexes on the configuration port.
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [WidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [HeightW-1:0] HeightReset = 13'd480;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  // One window column, top row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic [ColSumW-1:0] red;
    logic [ColSumW-1:0] green;
    logic [ColSumW-1:0] blue;
  } colsum_t;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    pix_t             pix;
    logic             last;
  } result_t;

  // Vertical 1-2-1 weighting of one channel.
  function automatic logic [ColSumW-1:0] vsum(input logic [ChanW-1:0] t,
                                              input logic [ChanW-1:0] m,
                                              input logic [ChanW-1:0] b);
    vsum = {2'b00, t} + {1'b0, m, 1'b0} + {2'b00, b};
  endfunction

  function automatic colsum_t col_weight(input column_t c);
    colsum_t s;
    s.red   = vsum(c.top.red,   c.mid.red,   c.bot.red);
    s.green = vsum(c.top.green, c.mid.green, c.bot.green);
    s.blue  = vsum(c.top.blue,  c.mid.blue,  c.bot.blue);
    col_weight = s;
  endfunction

  // Horizontal 1-2-1 weighting and the divide by sixteen. The sum never
  // exceeds 16*255, so the upper bits are already within 0..255.
  function automatic logic [ChanW-1:0] hsum(input logic [ColSumW-1:0] l,
                                            input logic [ColSumW-1:0] m,
                                            input logic [ColSumW-1:0] r);
    logic [WinSumW-1:0] s;
    s = {2'b00, l} + {1'b0, m, 1'b0} + {2'b00, r};
    hsum = s[WinSumW-1:4];
  endfunction

endpackage

// File: src/rgb_gaussian_blur_3x3_core.sv
// 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1, over 16) on an RGB raster stream.
// Input channel: in_valid_i / in_stall_o with red, green and blue; one beat
// is one pixel in raster order. Output channel: out_valid_o / out_stall_i;
// one beat per interior pixel with its row, column, the three filtered
// components and frame_last on the final interior pixel of the frame.
// Border pixels produce no beat.
// Throughput is one pixel per cycle while in_stall_o is low. The line store
// is one dual-port RAM holding both previous rows; each pixel reads it in the
// accept cycle and writes it back in the following cycle, so consecutive
// pixels never conflict. An accepted beat that completes a window reaches
// the output through the RAM read, the window shift in the chain of three
// column cells, then the sum into a four-entry result queue.
// When the receiver stalls, results collect in the queue and in_stall_o
// rises once the queue plus the two stages ahead of it could overflow.
// The APB port holds image_width at 0x0 and image_height at 0x4; a write
// restarts the frame at row 0, column 0. Reset sets 640 x 480, clears the
// counters, the window and the queue; the line store is not cleared, since
// its stale contents never reach a result.
module rgb_gaussian_blur_3x3_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Pixel input.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rgbg_pkg::ChanW-1:0]        red_in_i,
  input  logic [rgbg_pkg::ChanW-1:0]        green_in_i,
  input  logic [rgbg_pkg::ChanW-1:0]        blue_in_i,
  // Result output.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rgbg_pkg::RowW-1:0]         out_row_o,
  output logic [rgbg_pkg::ColW-1:0]         out_col_o,
  output logic [rgbg_pkg::ChanW-1:0]        red_out_o,
  output logic [rgbg_pkg::ChanW-1:0]        green_out_o,
  output logic [rgbg_pkg::ChanW-1:0]        blue_out_o,
  output logic                              frame_last_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgbg_pkg::AddrW-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [rgbg_pkg::WidthW-1:0]  width_q, width_d;
  logic [rgbg_pkg::HeightW-1:0] height_q, height_d;
  logic [rgbg_pkg::ColW-1:0]    col_q, col_d;
  logic [rgbg_pkg::RowW-1:0]    row_q, row_d;
  logic [rgbg_pkg::ColW-1:0]    last_col;
  logic [rgbg_pkg::RowW-1:0]    last_row;
  logic                         cfg_wr;
  logic                         accept;
  logic                         emits;

  // Stage B: line store data is back, the window shifts.
  logic                         b_valid_q;
  logic                         b_res_q;
  logic [rgbg_pkg::IdxW-1:0]    b_idx_q;
  rgbg_pkg::pix_t               b_pix_q;
  logic [rgbg_pkg::RowW-1:0]    b_row_q;
  logic [rgbg_pkg::ColW-1:0]    b_col_q;
  logic                         b_last_q;

  // Stage C: the window holds a complete neighborhood.
  logic                         c_res_q;
  logic [rgbg_pkg::RowW-1:0]    c_row_q;
  logic [rgbg_pkg::ColW-1:0]    c_col_q;
  logic                         c_last_q;

  logic [2*rgbg_pkg::PixW-1:0]  ram_rdata;
  logic [2*rgbg_pkg::PixW-1:0]  ram_wdata;
  rgbg_pkg::pix_t               ram_mid;
  rgbg_pkg::pix_t               ram_top;
  rgbg_pkg::pix_t               in_pix;

  rgbg_pkg::column_t            chain [4];
  rgbg_pkg::colsum_t            sums  [3];
  rgbg_pkg::result_t            res;
  rgbg_pkg::result_t            fifo_out;
  logic [rgbg_pkg::FifoCntW-1:0] fifo_cnt;
  logic [rgbg_pkg::FifoCntW:0]   inflight;

  assign in_pix = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      case (paddr[2])
        rgbg_pkg::RegWidth:  width_d  = pwdata[rgbg_pkg::WidthW-1:0];
        rgbg_pkg::RegHeight: height_d = pwdata[rgbg_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rgbg_pkg::RegWidth:  prdata = {{(32-rgbg_pkg::WidthW){1'b0}}, width_q};
      rgbg_pkg::RegHeight: prdata = {{(32-rgbg_pkg::HeightW){1'b0}}, height_q};
      default:             prdata = '0;
    endcase
  end

  // Last column and row after saturating the frame size to its legal range.
  always_comb begin
    if (width_q < 12'd3) begin
      last_col = 11'd2;
    end else if (width_q > 12'(rgbg_pkg::MaxWidth)) begin
      last_col = 11'(rgbg_pkg::MaxWidth - 1);
    end else begin
      last_col = 11'(width_q - 12'd1);
    end
    if (height_q < 13'd3) begin
      last_row = 12'd2;
    end else if (height_q > 13'(rgbg_pkg::MaxHeight)) begin
      last_row = 12'(rgbg_pkg::MaxHeight - 1);
    end else begin
      last_row = 12'(height_q - 13'd1);
    end
  end

  // Input acceptance leaves room for every result still on its way.
  assign inflight   = {1'b0, fifo_cnt} + {{rgbg_pkg::FifoCntW{1'b0}}, b_res_q}
                    + {{rgbg_pkg::FifoCntW{1'b0}}, c_res_q};
  assign in_stall_o = (inflight >= (rgbg_pkg::FifoCntW+1)'(rgbg_pkg::FifoDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign emits      = (row_q >= 12'd2) && (col_q >= 11'd2);

  // Raster position of the next pixel.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == last_col) begin
        col_d = '0;
        row_d = (row_q == last_row) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= rgbg_pkg::WidthReset;
      height_q  <= rgbg_pkg::HeightReset;
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      b_res_q   <= 1'b0;
      c_res_q   <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= accept;
      b_res_q   <= accept && emits;
      c_res_q   <= b_res_q;
    end
  end

  // Payload of the two stages.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_idx_q  <= col_q[rgbg_pkg::IdxW-1:0];
      b_pix_q  <= in_pix;
      b_row_q  <= row_q - 1'b1;
      b_col_q  <= col_q - 1'b1;
      b_last_q <= (row_q == last_row) && (col_q == last_col);
    end
    if (b_res_q) begin
      c_row_q  <= b_row_q;
      c_col_q  <= b_col_q;
      c_last_q <= b_last_q;
    end
  end

  // Line store word: the row just above in the upper half, two above in
  // the lower half. The current pixel pushes the upper half down.
  assign ram_mid   = ram_rdata[2*rgbg_pkg::PixW-1:rgbg_pkg::PixW];
  assign ram_top   = ram_rdata[rgbg_pkg::PixW-1:0];
  assign ram_wdata = {b_pix_q, ram_mid};

  rgbg_ram #(
    .Width (2 * rgbg_pkg::PixW),
    .Depth (rgbg_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_q[rgbg_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Chain of three column cells; the newest column enters on the right.
  assign chain[3] = '{top: ram_top, mid: ram_mid, bot: b_pix_q};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    rgbg_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (b_valid_q),
      .col_i   (chain[i+1]),
      .col_o   (chain[i]),
      .sum_o   (sums[i])
    );
  end

  // Horizontal weighting of the column sums forms the result.
  always_comb begin
    res.row       = c_row_q;
    res.col       = c_col_q;
    res.last      = c_last_q;
    res.pix.red   = rgbg_pkg::hsum(sums[0].red,   sums[1].red,   sums[2].red);
    res.pix.green = rgbg_pkg::hsum(sums[0].green, sums[1].green, sums[2].green);
    res.pix.blue  = rgbg_pkg::hsum(sums[0].blue,  sums[1].blue,  sums[2].blue);
  end

  rgbg_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (c_res_q),
    .data_i  (res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (fifo_out),
    .count_o (fifo_cnt)
  );

  assign out_row_o    = fifo_out.row;
  assign out_col_o    = fifo_out.col;
  assign red_out_o    = fifo_out.pix.red;
  assign green_out_o  = fifo_out.pix.green;
  assign blue_out_o   = fifo_out.pix.blue;
  assign frame_last_o = fifo_out.last;

endmodule

// File: src/rgbg_ram.sv
module rgbg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rgbg_win_cell.sv
module rgbg_win_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  rgbg_pkg::column_t col_i,
  output rgbg_pkg::column_t col_o,
  output rgbg_pkg::colsum_t sum_o
);

  rgbg_pkg::column_t col_q, col_d;

  // The cell takes its neighbor's column on every window shift.
  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = rgbg_pkg::col_weight(col_q);

endmodule

// File: src/rgbg_out_fifo.sv
module rgbg_out_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  rgbg_pkg::result_t                  data_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output rgbg_pkg::result_t                  data_o,
  output logic [rgbg_pkg::FifoCntW-1:0]      count_o
);

  rgbg_pkg::result_t                 mem_q [rgbg_pkg::FifoDepth];
  logic [rgbg_pkg::FifoPtrW-1:0]     wptr_q, wptr_d;
  logic [rgbg_pkg::FifoPtrW-1:0]     rptr_q, rptr_d;
  logic [rgbg_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: src/rgbg_checker.sv
`include "rgb_gaussian_blur_3x3_core_macros.svh"

module rgbg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [rgbg_pkg::RowW-1:0]  out_row_o,
  input logic [rgbg_pkg::ColW-1:0]  out_col_o,
  input logic [rgbg_pkg::ChanW-1:0] red_out_o,
  input logic [rgbg_pkg::ChanW-1:0] green_out_o,
  input logic [rgbg_pkg::ChanW-1:0] blue_out_o,
  input logic                       frame_last_o
);

  // A stalled output beat stays offered.
  `RGBG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output beat dropped while stalled")

  // A stalled output beat keeps its payload.
  `RGBG_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_row_o) && $stable(out_col_o) && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_last_o), "output payload changed while stalled")

  // Border positions in row 0 or column 0 never appear on the output.
  `RGBG_ASSERT_NOW(a_interior, out_valid_o, (out_row_o != '0) && (out_col_o != '0), "border pixel emitted")

  // An output beat appearing on an empty queue follows an accepted pixel through the pipeline.
  `RGBG_ASSERT_NOW(a_latency, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 3), "result without a matching input beat")

endmodule

bind rgb_gaussian_blur_3x3_core rgbg_checker u_rgbg_checker (.*);
